>>> rtl/gpfb_pkg.sv
`default_nettype none
package gpfb_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int GRID_CELLS  = 4096;
  localparam int ADDR_W      = $clog2(GRID_CELLS);
  localparam int VEL_W       = 24;
  localparam int POS_W       = 24;
  localparam int RECIP_W     = 24;
  localparam int CNT_W       = 7;
  localparam int RATIO_W     = FRAC_BITS + 1;
  localparam int W_W         = FRAC_BITS + 1;
  localparam int SCL_W       = POS_W + RECIP_W - FRAC_BITS;
  localparam int PC_W        = CNT_W + FRAC_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [W_W-1:0]   ONE_W    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PC_W-1:0]  ONE_P    = PC_W'(ONE_W);
  localparam logic [PC_W-1:0]  TWO_P    = PC_W'(ONE_W) << 1;
  localparam logic [PC_W-1:0]  HALF_P   = PC_W'(1) << (FRAC_BITS - 1);
  localparam logic [CNT_W-1:0] MIN_CELLS = CNT_W'(3);
  localparam int               TENTH    = ((1 << FRAC_BITS) + 5) / 10;
  localparam int               VMAX     = (1 << (VEL_W - 1)) - 1;
  localparam int               VMIN     = -(1 << (VEL_W - 1));

  typedef enum logic {
    CMD_WRITE    = 1'b0,
    CMD_PARTICLE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    SEL_X_NOW    = 2'd0,
    SEL_X_BEFORE = 2'd1,
    SEL_Y_NOW    = 2'd2,
    SEL_Y_BEFORE = 2'd3
  } sel_t;

  typedef enum logic [1:0] {
    REG_RECIP = 2'd0,
    REG_COLS  = 2'd1,
    REG_ROWS  = 2'd2,
    REG_RATIO = 2'd3
  } reg_t;

  typedef struct packed {
    logic                     cmd;
    logic [1:0]               grid_select;
    logic [ADDR_W-1:0]        grid_index;
    logic signed [VEL_W-1:0]  grid_value;
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic                     last_particle;
  } in_item_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] new_vel_x;
    logic signed [VEL_W-1:0] new_vel_y;
    logic                    pass_done;
  } out_item_t;

  typedef struct packed {
    logic [RECIP_W-1:0] cell_size_recip;
    logic [CNT_W-1:0]   grid_columns;
    logic [CNT_W-1:0]   grid_rows;
    logic [RATIO_W-1:0] pic_ratio;
  } cfg_t;

  typedef struct packed {
    logic                    cmd;
    logic [1:0]              grid_select;
    logic [ADDR_W-1:0]       grid_index;
    logic signed [VEL_W-1:0] grid_value;
    logic [SCL_W-1:0]        scl_x;
    logic [SCL_W-1:0]        scl_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic                    last;
  } queue_item_t;

endpackage
`default_nettype wire

>>> rtl/gpfb_ram.sv
`default_nettype none
module gpfb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> rtl/gpfb_front.sv
`default_nettype none
module gpfb_front #(
  parameter int QUEUE_DEPTH = gpfb_pkg::QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire gpfb_pkg::in_item_t     in_data,
  input  wire gpfb_pkg::cfg_t         cfg,
  output logic                        q_valid,
  output gpfb_pkg::queue_item_t       q_item,
  input  wire logic                   q_pop
);

  localparam int IW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int PROD_W = gpfb_pkg::POS_W + gpfb_pkg::RECIP_W;

  logic                  f_v_r;
  gpfb_pkg::queue_item_t f_item_r, f_item_nxt;
  gpfb_pkg::queue_item_t mem_r [QUEUE_DEPTH];
  logic [IW-1:0]         wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [PROD_W-1:0]     prod_x, prod_y;
  logic                  accept, push, pop;

  assign busy   = ({1'b0, cnt_r} + (CW+1)'(f_v_r)) >= (CW+1)'(QUEUE_DEPTH);
  assign accept = start && !busy;
  assign push   = f_v_r;
  assign pop    = q_pop && q_valid;

  // scale world positions to cell units here, clamp later in the back end
  assign prod_x = PROD_W'(in_data.pos_x) * PROD_W'(cfg.cell_size_recip);
  assign prod_y = PROD_W'(in_data.pos_y) * PROD_W'(cfg.cell_size_recip);

  always_comb begin
    f_item_nxt.cmd         = in_data.cmd;
    f_item_nxt.grid_select = in_data.grid_select;
    f_item_nxt.grid_index  = in_data.grid_index;
    f_item_nxt.grid_value  = in_data.grid_value;
    f_item_nxt.scl_x       = prod_x[gpfb_pkg::FRAC_BITS +: gpfb_pkg::SCL_W];
    f_item_nxt.scl_y       = prod_y[gpfb_pkg::FRAC_BITS +: gpfb_pkg::SCL_W];
    f_item_nxt.vel_x       = in_data.vel_x;
    f_item_nxt.vel_y       = in_data.vel_y;
    f_item_nxt.last        = in_data.last_particle;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r    <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      f_v_r    <= accept;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= f_item_r;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (f_v_r && cnt_r == CW'(QUEUE_DEPTH)) |-> pop)
    else $error("beat pushed into full queue");
`endif

endmodule
`default_nettype wire

>>> rtl/gpfb_back.sv
`default_nettype none
module gpfb_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire gpfb_pkg::cfg_t         cfg,
  input  wire logic                   q_valid,
  input  wire gpfb_pkg::queue_item_t  q_item,
  output logic                        q_pop,
  output logic                        out_strobe,
  output gpfb_pkg::out_item_t         out_data
);

  localparam int FB     = gpfb_pkg::FRAC_BITS;
  localparam int VW     = gpfb_pkg::VEL_W;
  localparam int AW     = gpfb_pkg::ADDR_W;
  localparam int CW     = gpfb_pkg::CNT_W;
  localparam int PW     = gpfb_pkg::PC_W;
  localparam int WW     = gpfb_pkg::W_W;
  localparam int ACC_P  = VW + WW + 3;
  localparam int ACC_C  = VW + WW + 5;
  localparam int DIFF_W = VW + 1;
  localparam int PICF_W = ACC_P - FB;
  localparam int CHGF_W = ACC_C - FB + 1;
  localparam int MIX_W  = CHGF_W + WW + 4;
  localparam int SH_W   = MIX_W - FB;
  localparam int CELL_W = 2 * CW + 1;

  typedef struct packed {
    logic [3:0][AW-1:0] k;
    logic [2:0][WW-1:0] w;
  } smp_t;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                              input logic [CW-1:0] r,
                                              input logic [CW-1:0] rows);
    logic [CELL_W-1:0] t;
    t = CELL_W'(c) * CELL_W'(rows) + CELL_W'(r);
    return t[AW-1:0];
  endfunction

  function automatic smp_t corners(input logic [PW-1:0] cx, input logic [PW-1:0] cy,
                                   input logic [CW-1:0] cols, input logic [CW-1:0] rows);
    logic [CW-1:0]   i, j, ip, jp;
    logic [CW:0]     i1, j1, clim, rlim;
    logic [FB-1:0]   fx, fy;
    logic [WW-1:0]   ex, ey;
    logic [2*WW-1:0] p0, p1, p2;
    smp_t            s;
    i    = cx[PW-1:FB];
    j    = cy[PW-1:FB];
    fx   = cx[FB-1:0];
    fy   = cy[FB-1:0];
    ex   = gpfb_pkg::ONE_W - WW'(fx);
    ey   = gpfb_pkg::ONE_W - WW'(fy);
    i1   = {1'b0, i} + 1'b1;
    j1   = {1'b0, j} + 1'b1;
    clim = {1'b0, cols} - (CW+1)'(2);
    rlim = {1'b0, rows} - (CW+1)'(2);
    ip   = (i1 < clim) ? i1[CW-1:0] : clim[CW-1:0];
    jp   = (j1 < rlim) ? j1[CW-1:0] : rlim[CW-1:0];
    p0   = (2*WW)'(ex) * (2*WW)'(ey);
    p1   = (2*WW)'(fx) * (2*WW)'(ey);
    p2   = (2*WW)'(fx) * (2*WW)'(fy);
    s.w[0] = p0[FB +: WW];
    s.w[1] = p1[FB +: WW];
    s.w[2] = p2[FB +: WW];
    s.k[0] = cell_addr(i, j, rows);
    s.k[1] = cell_addr(ip, j, rows);
    s.k[2] = cell_addr(ip, jp, rows);
    s.k[3] = cell_addr(i, jp, rows);
    return s;
  endfunction

  function automatic logic signed [VW-1:0] sat(input logic signed [SH_W-1:0] v);
    if (v > SH_W'(gpfb_pkg::VMAX)) begin
      return VW'(gpfb_pkg::VMAX);
    end else if (v < SH_W'(gpfb_pkg::VMIN)) begin
      return VW'(gpfb_pkg::VMIN);
    end
    return v[VW-1:0];
  endfunction

  // effective configuration
  logic [CW-1:0]              cols_e, rows_e;
  logic [PW-1:0]              hi_x, hi_y;
  logic [gpfb_pkg::RATIO_W-1:0] ratio_e;

  assign cols_e  = (cfg.grid_columns < gpfb_pkg::MIN_CELLS) ? gpfb_pkg::MIN_CELLS
                                                             : cfg.grid_columns;
  assign rows_e  = (cfg.grid_rows < gpfb_pkg::MIN_CELLS) ? gpfb_pkg::MIN_CELLS
                                                         : cfg.grid_rows;
  assign hi_x    = {cols_e - 1'b1, {FB{1'b0}}};
  assign hi_y    = {rows_e - 1'b1, {FB{1'b0}}};
  assign ratio_e = (cfg.pic_ratio > gpfb_pkg::ONE_W) ? gpfb_pkg::ONE_W : cfg.pic_ratio;

  // stage 1: clamp
  logic                    s1_v_r, s1_ready;
  logic                    s1_cmd_r;
  logic [1:0]              s1_sel_r;
  logic [AW-1:0]           s1_idx_r;
  logic signed [VW-1:0]    s1_val_r, s1_vx_r, s1_vy_r;
  logic [PW-1:0]           s1_px_r, s1_py_r, px_c, py_c;
  logic                    s1_last_r;

  // stage 2: corners and weights
  logic                    s2_v_r, s2_ready;
  logic                    s2_cmd_r;
  logic [1:0]              s2_sel_r;
  logic [AW-1:0]           s2_idx_r;
  logic signed [VW-1:0]    s2_val_r, s2_vx_r, s2_vy_r;
  smp_t                    s2_sx_r, s2_sy_r, sx_c, sy_c;
  logic                    s2_last_r, s2_wall_r;

  // read sequencer
  logic                    seq_v_r, seq_ready, seq_done, seq_load;
  logic [1:0]              seq_beat_r, seq_beat_nxt;
  logic                    seq_cmd_r;
  logic [1:0]              seq_sel_r;
  logic [AW-1:0]           seq_idx_r;
  logic signed [VW-1:0]    seq_val_r, seq_vx_r, seq_vy_r;
  logic [3:0][AW-1:0]      seq_kx_r, seq_ky_r;
  logic [3:0][WW-1:0]      seq_wx_r, seq_wy_r;
  logic                    seq_last_r, seq_wall_r;

  assign s1_ready = !s1_v_r || s2_ready;
  assign s2_ready = !s2_v_r || seq_ready;
  assign seq_done = seq_v_r && (seq_cmd_r == gpfb_pkg::CMD_WRITE || seq_beat_r == 2'd3);
  assign seq_ready = !seq_v_r || seq_done;
  assign seq_load  = s2_v_r && seq_ready;
  assign q_pop     = q_valid && s1_ready;

  always_comb begin
    px_c = (q_item.scl_x < gpfb_pkg::SCL_W'(gpfb_pkg::ONE_P)) ? gpfb_pkg::ONE_P :
           (q_item.scl_x > gpfb_pkg::SCL_W'(hi_x)) ? hi_x : q_item.scl_x[PW-1:0];
    py_c = (q_item.scl_y < gpfb_pkg::SCL_W'(gpfb_pkg::ONE_P)) ? gpfb_pkg::ONE_P :
           (q_item.scl_y > gpfb_pkg::SCL_W'(hi_y)) ? hi_y : q_item.scl_y[PW-1:0];
    // x samples a half cell down in y, y samples a half cell left in x
    sx_c = corners(s1_px_r, s1_py_r - gpfb_pkg::HALF_P, cols_e, rows_e);
    sy_c = corners(s1_px_r - gpfb_pkg::HALF_P, s1_py_r, cols_e, rows_e);
    if (seq_load) begin
      seq_beat_nxt = 2'd0;
    end else if (seq_done) begin
      seq_beat_nxt = 2'd0;
    end else if (seq_v_r) begin
      seq_beat_nxt = seq_beat_r + 2'd1;
    end else begin
      seq_beat_nxt = seq_beat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      seq_v_r    <= 1'b0;
      seq_beat_r <= 2'd0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= q_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (seq_ready) begin
        seq_v_r <= s2_v_r;
      end
      seq_beat_r <= seq_beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd_r  <= q_item.cmd;
      s1_sel_r  <= q_item.grid_select;
      s1_idx_r  <= q_item.grid_index;
      s1_val_r  <= q_item.grid_value;
      s1_vx_r   <= q_item.vel_x;
      s1_vy_r   <= q_item.vel_y;
      s1_last_r <= q_item.last;
      s1_px_r   <= px_c;
      s1_py_r   <= py_c;
    end
    if (s2_ready && s1_v_r) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_sel_r  <= s1_sel_r;
      s2_idx_r  <= s1_idx_r;
      s2_val_r  <= s1_val_r;
      s2_vx_r   <= s1_vx_r;
      s2_vy_r   <= s1_vy_r;
      s2_last_r <= s1_last_r;
      s2_sx_r   <= sx_c;
      s2_sy_r   <= sy_c;
      s2_wall_r <= (s1_px_r < gpfb_pkg::TWO_P);
    end
    if (seq_load) begin
      seq_cmd_r   <= s2_cmd_r;
      seq_sel_r   <= s2_sel_r;
      seq_idx_r   <= s2_idx_r;
      seq_val_r   <= s2_val_r;
      seq_vx_r    <= s2_vx_r;
      seq_vy_r    <= s2_vy_r;
      seq_last_r  <= s2_last_r;
      seq_wall_r  <= s2_wall_r;
      seq_kx_r    <= s2_sx_r.k;
      seq_ky_r    <= s2_sy_r.k;
      seq_wx_r    <= {gpfb_pkg::ONE_W - s2_sx_r.w[0] - s2_sx_r.w[1] - s2_sx_r.w[2],
                      s2_sx_r.w};
      seq_wy_r    <= {gpfb_pkg::ONE_W - s2_sy_r.w[0] - s2_sy_r.w[1] - s2_sy_r.w[2],
                      s2_sy_r.w};
    end
  end

  // grid stores
  logic                 is_wr;
  logic [AW-1:0]        addr_x, addr_y;
  logic [VW-1:0]        xn_rd, xb_rd, yn_rd, yb_rd;

  assign is_wr  = seq_v_r && (seq_cmd_r == gpfb_pkg::CMD_WRITE);
  assign addr_x = (seq_cmd_r == gpfb_pkg::CMD_WRITE) ? seq_idx_r : seq_kx_r[seq_beat_r];
  assign addr_y = (seq_cmd_r == gpfb_pkg::CMD_WRITE) ? seq_idx_r : seq_ky_r[seq_beat_r];

  gpfb_ram #(.WIDTH(VW), .DEPTH(gpfb_pkg::GRID_CELLS)) u_ram_x_now (
    .clk(clk), .we(is_wr && seq_sel_r == gpfb_pkg::SEL_X_NOW), .addr(addr_x),
    .wdata(seq_val_r), .rdata(xn_rd));
  gpfb_ram #(.WIDTH(VW), .DEPTH(gpfb_pkg::GRID_CELLS)) u_ram_x_before (
    .clk(clk), .we(is_wr && seq_sel_r == gpfb_pkg::SEL_X_BEFORE), .addr(addr_x),
    .wdata(seq_val_r), .rdata(xb_rd));
  gpfb_ram #(.WIDTH(VW), .DEPTH(gpfb_pkg::GRID_CELLS)) u_ram_y_now (
    .clk(clk), .we(is_wr && seq_sel_r == gpfb_pkg::SEL_Y_NOW), .addr(addr_y),
    .wdata(seq_val_r), .rdata(yn_rd));
  gpfb_ram #(.WIDTH(VW), .DEPTH(gpfb_pkg::GRID_CELLS)) u_ram_y_before (
    .clk(clk), .we(is_wr && seq_sel_r == gpfb_pkg::SEL_Y_BEFORE), .addr(addr_y),
    .wdata(seq_val_r), .rdata(yb_rd));

  // read tag, registered from the sequencer beat
  logic                 t_v_r;
  logic [1:0]           t_n_r;
  logic [WW-1:0]        t_wx_r, t_wy_r;
  logic signed [VW-1:0] t_vx_r, t_vy_r;
  logic                 t_last_r, t_wall_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else begin
      t_v_r <= seq_v_r && (seq_cmd_r == gpfb_pkg::CMD_PARTICLE);
    end
  end

  always_ff @(posedge clk) begin
    t_n_r    <= seq_beat_r;
    t_wx_r   <= seq_wx_r[seq_beat_r];
    t_wy_r   <= seq_wy_r[seq_beat_r];
    t_vx_r   <= seq_vx_r;
    t_vy_r   <= seq_vy_r;
    t_last_r <= seq_last_r;
    t_wall_r <= seq_wall_r;
  end

  // accumulate weighted corners
  logic signed [ACC_P-1:0]  acc_px_r, acc_py_r, prod_px, prod_py;
  logic signed [ACC_C-1:0]  acc_cx_r, acc_cy_r, prod_cx, prod_cy;
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [WW:0]       wxs, wys;
  logic                     m_done_r;
  logic signed [VW-1:0]     m_vx_r, m_vy_r;
  logic                     m_last_r, m_wall_r;

  assign wxs     = $signed({1'b0, t_wx_r});
  assign wys     = $signed({1'b0, t_wy_r});
  assign dx      = DIFF_W'($signed(xn_rd)) - DIFF_W'($signed(xb_rd));
  assign dy      = DIFF_W'($signed(yn_rd)) - DIFF_W'($signed(yb_rd));
  assign prod_px = ACC_P'(wxs) * ACC_P'($signed(xn_rd));
  assign prod_py = ACC_P'(wys) * ACC_P'($signed(yn_rd));
  assign prod_cx = ACC_C'(wxs) * ACC_C'(dx);
  assign prod_cy = ACC_C'(wys) * ACC_C'(dy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_done_r <= 1'b0;
    end else begin
      m_done_r <= t_v_r && (t_n_r == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (t_v_r) begin
      acc_px_r <= ((t_n_r == 2'd0) ? '0 : acc_px_r) + prod_px;
      acc_py_r <= ((t_n_r == 2'd0) ? '0 : acc_py_r) + prod_py;
      acc_cx_r <= ((t_n_r == 2'd0) ? '0 : acc_cx_r) + prod_cx;
      acc_cy_r <= ((t_n_r == 2'd0) ? '0 : acc_cy_r) + prod_cy;
    end
    m_vx_r   <= t_vx_r;
    m_vy_r   <= t_vy_r;
    m_last_r <= t_last_r;
    m_wall_r <= t_wall_r;
  end

  // blend terms
  logic signed [PICF_W-1:0] picf_x, picf_y;
  logic signed [CHGF_W-1:0] chgf_x, chgf_y;
  logic signed [WW:0]       rs, irs;
  logic signed [MIX_W-1:0]  f_mx1_r, f_mx2_r, f_my1_r, f_my2_r;
  logic                     f1_v_r, f_last_r, f_wall_r;

  assign picf_x = PICF_W'(acc_px_r >>> FB);
  assign picf_y = PICF_W'(acc_py_r >>> FB);
  assign chgf_x = CHGF_W'(m_vx_r) + CHGF_W'(acc_cx_r >>> FB);
  assign chgf_y = CHGF_W'(m_vy_r) + CHGF_W'(acc_cy_r >>> FB);
  assign rs     = $signed({1'b0, ratio_e});
  assign irs    = $signed({1'b0, gpfb_pkg::ONE_W - ratio_e});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= m_done_r;
    end
  end

  always_ff @(posedge clk) begin
    f_mx1_r  <= MIX_W'(rs) * MIX_W'(picf_x);
    f_mx2_r  <= MIX_W'(irs) * MIX_W'(chgf_x);
    f_my1_r  <= MIX_W'(rs) * MIX_W'(picf_y);
    f_my2_r  <= MIX_W'(irs) * MIX_W'(chgf_y);
    f_last_r <= m_last_r;
    f_wall_r <= m_wall_r;
  end

  // final sum, saturate, left wall nudge
  logic signed [MIX_W-1:0] sum_x, sum_y;
  logic signed [VW-1:0]    vx_s, vy_s, vy_f;
  logic                    out_strobe_r;
  gpfb_pkg::out_item_t     out_data_r;

  always_comb begin
    sum_x = f_mx1_r + f_mx2_r;
    sum_y = f_my1_r + f_my2_r;
    vx_s  = sat(SH_W'(sum_x >>> FB));
    vy_s  = sat(SH_W'(sum_y >>> FB));
    vy_f  = vy_s;
    if (f_wall_r && vy_s < VW'(gpfb_pkg::TENTH)) begin
      vy_f = sat(SH_W'(vy_s) + SH_W'(gpfb_pkg::TENTH));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.new_vel_x <= vx_s;
    out_data_r.new_vel_y <= vy_f;
    out_data_r.pass_done <= f_last_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

`ifndef NO_ASSERTIONS
  a_beat_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_beat_r != 2'd0) |-> (seq_v_r && seq_cmd_r == gpfb_pkg::CMD_PARTICLE))
    else $error("sequencer beat advanced without a particle");
  a_acc_done: assert property (@(posedge clk) disable iff (!rst_n)
    (t_v_r && t_n_r == 2'd3) |=> m_done_r)
    else $error("last corner beat did not close the sum");
  a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    m_done_r |=> !m_done_r)
    else $error("two particles finished back to back");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    f1_v_r |=> out_strobe_r)
    else $error("blend stage lost a result");
`endif

endmodule
`default_nettype wire

>>> rtl/grid_to_particle_flip_blend.sv
`default_nettype none
// Channel   Ports                                   Direction  Handshake
// input     start, busy, in_data                    in         start && !busy
// result    out_strobe, out_data                    out        one-cycle strobe
// config    psel, penable, pwrite, paddr, pwdata,   in/out     APB, pready tied high
//           prdata, pready
//
// A grid write needs a single access to the store port; a particle reads its four
// bilinear corners one after another from the single-port velocity stores, so the
// sequencer takes no new item until a particle's last corner has been read.
// rst_n is synchronous; it clears control state, grid stores come up unknown.
// busy rises as queue plus front beat reach the depth; results cannot be held off.
module grid_to_particle_flip_blend #(
  parameter int QUEUE_DEPTH = gpfb_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire gpfb_pkg::in_item_t              in_data,
  output logic                                 out_strobe,
  output gpfb_pkg::out_item_t                  out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [gpfb_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [gpfb_pkg::PDATA_W-1:0]    pwdata,
  output logic      [gpfb_pkg::PDATA_W-1:0]    prdata,
  output logic                                 pready
);

  gpfb_pkg::cfg_t        cfg_r;
  gpfb_pkg::reg_t        reg_sel;
  gpfb_pkg::queue_item_t q_item;
  logic                  q_valid, q_pop, cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = gpfb_pkg::reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_size_recip <= gpfb_pkg::RECIP_W'(gpfb_pkg::ONE_W);
      cfg_r.grid_columns    <= gpfb_pkg::CNT_W'(64);
      cfg_r.grid_rows       <= gpfb_pkg::CNT_W'(64);
      cfg_r.pic_ratio       <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        gpfb_pkg::REG_RECIP: cfg_r.cell_size_recip <= pwdata[gpfb_pkg::RECIP_W-1:0];
        gpfb_pkg::REG_COLS:  cfg_r.grid_columns    <= pwdata[gpfb_pkg::CNT_W-1:0];
        gpfb_pkg::REG_ROWS:  cfg_r.grid_rows       <= pwdata[gpfb_pkg::CNT_W-1:0];
        gpfb_pkg::REG_RATIO: cfg_r.pic_ratio       <= pwdata[gpfb_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      gpfb_pkg::REG_RECIP: prdata = gpfb_pkg::PDATA_W'(cfg_r.cell_size_recip);
      gpfb_pkg::REG_COLS:  prdata = gpfb_pkg::PDATA_W'(cfg_r.grid_columns);
      gpfb_pkg::REG_ROWS:  prdata = gpfb_pkg::PDATA_W'(cfg_r.grid_rows);
      gpfb_pkg::REG_RATIO: prdata = gpfb_pkg::PDATA_W'(cfg_r.pic_ratio);
      default:             prdata = '0;
    endcase
  end

  gpfb_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  gpfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

>>> dv/gpfb_checker.sv
`timescale 1ns / 1ps
module gpfb_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  wire gpfb_pkg::in_item_t           in_data,
  input  wire logic                         out_strobe,
  input  wire gpfb_pkg::out_item_t          out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic                         pready,
  input  wire logic [gpfb_pkg::PADDR_W-1:0] paddr,
  input  wire logic [gpfb_pkg::PDATA_W-1:0] pwdata,
  output int                                errors,
  output int                                pending
);

  localparam longint UNIT = longint'(1) << gpfb_pkg::FRAC_BITS;
  localparam longint HALF_UNIT = UNIT / 2;

  int                  vel_store [4][gpfb_pkg::GRID_CELLS];
  longint              recip, cols_reg, rows_reg, ratio_reg;
  gpfb_pkg::out_item_t expected_vel [$];

  assign pending = expected_vel.size();

  function automatic longint sat_vel(longint v);
    if (v > gpfb_pkg::VMAX) return gpfb_pkg::VMAX;
    if (v < gpfb_pkg::VMIN) return gpfb_pkg::VMIN;
    return v;
  endfunction

  function automatic longint to_cells(longint pos, longint cnt);
    longint p;
    p = (pos * recip) >>> gpfb_pkg::FRAC_BITS;
    if (p < UNIT) p = UNIT;
    if (p > ((cnt - 1) << gpfb_pkg::FRAC_BITS)) p = (cnt - 1) << gpfb_pkg::FRAC_BITS;
    return p;
  endfunction

  // bilinear PIC and FLIP for one staggered component, then blend
  function automatic longint blend_axis(int now_sel, longint cx, longint cy, longint cols,
                                        longint rows, longint vel, longint ratio);
    longint i, j, fx, fy, ex, ey, ip, jp, pic, chg, a, b;
    longint w [4];
    longint c [4];
    i = cx >>> gpfb_pkg::FRAC_BITS;
    j = cy >>> gpfb_pkg::FRAC_BITS;
    fx = cx & (UNIT - 1);
    fy = cy & (UNIT - 1);
    ex = UNIT - fx;
    ey = UNIT - fy;
    ip = (i + 1 < cols - 2) ? i + 1 : cols - 2;
    jp = (j + 1 < rows - 2) ? j + 1 : rows - 2;
    w[0] = (ex * ey) >>> gpfb_pkg::FRAC_BITS;
    w[1] = (fx * ey) >>> gpfb_pkg::FRAC_BITS;
    w[2] = (fx * fy) >>> gpfb_pkg::FRAC_BITS;
    w[3] = UNIT - w[0] - w[1] - w[2];
    c[0] = (i * rows + j) % gpfb_pkg::GRID_CELLS;
    c[1] = (ip * rows + j) % gpfb_pkg::GRID_CELLS;
    c[2] = (ip * rows + jp) % gpfb_pkg::GRID_CELLS;
    c[3] = (i * rows + jp) % gpfb_pkg::GRID_CELLS;
    pic = 0;
    chg = 0;
    for (int n = 0; n < 4; n++) begin
      a = vel_store[now_sel][c[n]];
      b = vel_store[now_sel + 1][c[n]];
      pic += w[n] * a;
      chg += w[n] * (a - b);
    end
    pic = pic >>> gpfb_pkg::FRAC_BITS;
    chg = (vel * UNIT + chg) >>> gpfb_pkg::FRAC_BITS;
    return sat_vel((ratio * pic + (UNIT - ratio) * chg) >>> gpfb_pkg::FRAC_BITS);
  endfunction

  function automatic gpfb_pkg::out_item_t transfer_particle(gpfb_pkg::in_item_t it);
    longint cols, rows, ratio, px, py, vy;
    gpfb_pkg::out_item_t r;
    cols = (cols_reg < 3) ? 3 : cols_reg;
    rows = (rows_reg < 3) ? 3 : rows_reg;
    ratio = (ratio_reg > UNIT) ? UNIT : ratio_reg;
    px = to_cells(longint'(it.pos_x), cols);
    py = to_cells(longint'(it.pos_y), rows);
    r.new_vel_x = gpfb_pkg::VEL_W'(blend_axis(int'(gpfb_pkg::SEL_X_NOW), px, py - HALF_UNIT,
                                              cols, rows, longint'(it.vel_x), ratio));
    vy = blend_axis(int'(gpfb_pkg::SEL_Y_NOW), px - HALF_UNIT, py, cols, rows,
                    longint'(it.vel_y), ratio);
    // nudge off the left wall
    if (px < 2 * UNIT && vy < gpfb_pkg::TENTH) vy = sat_vel(vy + gpfb_pkg::TENTH);
    r.new_vel_y = gpfb_pkg::VEL_W'(vy);
    r.pass_done = it.last_particle;
    return r;
  endfunction

  always @(posedge clk) begin
    gpfb_pkg::out_item_t e;
    int nerr;
    nerr = 0;
    if (!rst_n) begin
      errors <= 0;
      recip = UNIT;
      cols_reg = 64;
      rows_reg = 64;
      ratio_reg = 0;
      expected_vel.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (gpfb_pkg::reg_t'(paddr[3:2]))
          gpfb_pkg::REG_RECIP: recip = longint'(pwdata[gpfb_pkg::RECIP_W-1:0]);
          gpfb_pkg::REG_COLS:  cols_reg = longint'(pwdata[gpfb_pkg::CNT_W-1:0]);
          gpfb_pkg::REG_ROWS:  rows_reg = longint'(pwdata[gpfb_pkg::CNT_W-1:0]);
          gpfb_pkg::REG_RATIO: ratio_reg = longint'(pwdata[gpfb_pkg::RATIO_W-1:0]);
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (expected_vel.size() == 0) begin
          $error("result beat with nothing expected");
          nerr++;
        end else begin
          e = expected_vel.pop_front();
          if (out_data.new_vel_x !== e.new_vel_x) begin
            $error("new_vel_x: expected %0d, got %0d", e.new_vel_x, out_data.new_vel_x);
            nerr++;
          end
          if (out_data.new_vel_y !== e.new_vel_y) begin
            $error("new_vel_y: expected %0d, got %0d", e.new_vel_y, out_data.new_vel_y);
            nerr++;
          end
          if (out_data.pass_done !== e.pass_done) begin
            $error("pass_done: expected %0d, got %0d", e.pass_done, out_data.pass_done);
            nerr++;
          end
        end
      end
      if (start && !busy) begin
        if (gpfb_pkg::cmd_t'(in_data.cmd) == gpfb_pkg::CMD_WRITE)
          vel_store[in_data.grid_select][in_data.grid_index] = int'(in_data.grid_value);
        else
          expected_vel.push_back(transfer_particle(in_data));
      end
      errors <= errors + nerr;
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int STALL_LIMIT = 5000;
  // every grid used below has at most this many cells
  localparam int FILL_CELLS  = 64;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  gpfb_pkg::in_item_t           in_data;
  logic                         out_strobe;
  gpfb_pkg::out_item_t          out_data;
  logic                         psel, penable, pwrite, pready;
  logic [gpfb_pkg::PADDR_W-1:0] paddr;
  logic [gpfb_pkg::PDATA_W-1:0] pwdata, prdata;
  int                           errors, pending, quiet_cycles;
  bit                           no_gaps;

  grid_to_particle_flip_blend i_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_strobe, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  gpfb_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_data, .out_strobe, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog on cycles without an accepted beat, a result or a register access
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic send(gpfb_pkg::in_item_t it);
    int gap;
    bit taken;
    gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    taken = 1'b0;
    // busy is settled mid-cycle and holds until the accepting edge
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
  endtask

  task automatic grid_write(gpfb_pkg::sel_t sel, int idx, int val);
    gpfb_pkg::in_item_t it;
    logic [159:0]       junk;
    junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = gpfb_pkg::in_item_t'(junk[$bits(gpfb_pkg::in_item_t)-1:0]);
    it.cmd = gpfb_pkg::CMD_WRITE;
    it.grid_select = sel;
    it.grid_index = gpfb_pkg::ADDR_W'(idx);
    it.grid_value = gpfb_pkg::VEL_W'(val);
    send(it);
  endtask

  task automatic particle(int px, int py, int vx, int vy, bit last);
    gpfb_pkg::in_item_t it;
    logic [159:0]       junk;
    junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = gpfb_pkg::in_item_t'(junk[$bits(gpfb_pkg::in_item_t)-1:0]);
    it.cmd = gpfb_pkg::CMD_PARTICLE;
    it.pos_x = gpfb_pkg::POS_W'(px);
    it.pos_y = gpfb_pkg::POS_W'(py);
    it.vel_x = gpfb_pkg::VEL_W'(vx);
    it.vel_y = gpfb_pkg::VEL_W'(vy);
    it.last_particle = last;
    send(it);
  endtask

  // wait out results and the write pipeline, then write one register
  task automatic set_reg(gpfb_pkg::reg_t r, int val);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= gpfb_pkg::PADDR_W'({r, 2'b00});
    pwdata <= gpfb_pkg::PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int rand_vel();
    case ($urandom_range(0, 5))
      0: return gpfb_pkg::VMAX;
      1: return gpfb_pkg::VMIN;
      2: return $urandom_range(0, 1 << 18) - (1 << 17);
      default: return int'($urandom) <<< 8 >>> 8;
    endcase
  endfunction

  function automatic int rand_pos();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1 << 24) & 24'hFFFFFF;
      1: return $urandom_range(0, 3 << 16);
      default: return $urandom_range(0, 1 << 23);
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 3)
        grid_write(gpfb_pkg::sel_t'($urandom_range(0, 3)),
                   ($urandom_range(0, 1) == 0) ? $urandom_range(0, FILL_CELLS - 1)
                                               : $urandom_range(0, gpfb_pkg::GRID_CELLS - 1),
                   rand_vel());
      else
        particle(rand_pos(), rand_pos(), rand_vel(), rand_vel(), $urandom_range(0, 1));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    no_gaps = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // keep every grid small so a short fill covers all cells a particle can touch
    set_reg(gpfb_pkg::REG_COLS, 8);
    set_reg(gpfb_pkg::REG_ROWS, 8);
    for (int s = 0; s < 4; s++)
      for (int c = 0; c < FILL_CELLS; c++)
        grid_write(gpfb_pkg::sel_t'(s), c, $urandom_range(0, 1 << 20) - (1 << 19));
    no_gaps = 1'b0;

    // directed: extremes, wall nudge, saturation
    grid_write(gpfb_pkg::SEL_X_NOW, gpfb_pkg::GRID_CELLS - 1, gpfb_pkg::VMAX);
    grid_write(gpfb_pkg::SEL_X_BEFORE, 0, gpfb_pkg::VMIN);
    grid_write(gpfb_pkg::SEL_Y_NOW, 9, gpfb_pkg::VMIN);
    grid_write(gpfb_pkg::SEL_Y_BEFORE, 9, gpfb_pkg::VMAX);
    particle(0, 0, gpfb_pkg::VMAX, gpfb_pkg::VMIN, 1'b0);
    particle(24'hFFFFFF, 24'hFFFFFF, gpfb_pkg::VMIN, gpfb_pkg::VMAX, 1'b1);
    particle(32'h18000, 32'h18000, 0, -1000, 1'b0);
    particle(32'h10000, 32'h20000, gpfb_pkg::VMAX, gpfb_pkg::VMAX, 1'b1);
    particle(32'h1FFFF, 32'h3F0000, -5, 6553, 1'b0);
    set_reg(gpfb_pkg::REG_RATIO, 65536);
    particle(32'h18000, 32'h18000, 0, gpfb_pkg::VMIN, 1'b0);
    particle(32'h20000, 32'h30000, 0, 0, 1'b1);
    set_reg(gpfb_pkg::REG_RATIO, 131071);
    particle(32'h28000, 32'h28000, 100, 100, 1'b0);
    set_reg(gpfb_pkg::REG_COLS, 0);
    set_reg(gpfb_pkg::REG_ROWS, 0);
    set_reg(gpfb_pkg::REG_RECIP, 1);
    particle(24'hFFFFFF, 24'hFFFFFF, 1, 1, 1'b1);
    set_reg(gpfb_pkg::REG_RECIP, 24'hFFFFFF);
    particle(12345, 54321, -1, gpfb_pkg::VMAX, 1'b0);

    // random phases across register settings
    set_reg(gpfb_pkg::REG_RECIP, 65536);
    set_reg(gpfb_pkg::REG_COLS, 8);
    set_reg(gpfb_pkg::REG_ROWS, 8);
    set_reg(gpfb_pkg::REG_RATIO, 0);
    random_phase(135);
    set_reg(gpfb_pkg::REG_COLS, 3);
    set_reg(gpfb_pkg::REG_ROWS, 21);
    set_reg(gpfb_pkg::REG_RATIO, 32768);
    random_phase(135);
    set_reg(gpfb_pkg::REG_COLS, 21);
    set_reg(gpfb_pkg::REG_ROWS, 3);
    set_reg(gpfb_pkg::REG_RECIP, 24'h20000);
    set_reg(gpfb_pkg::REG_RATIO, 65536);
    random_phase(135);
    set_reg(gpfb_pkg::REG_COLS, 4);
    set_reg(gpfb_pkg::REG_ROWS, 16);
    set_reg(gpfb_pkg::REG_RECIP, 24'h4000);
    set_reg(gpfb_pkg::REG_RATIO, 90000);
    random_phase(135);
    set_reg(gpfb_pkg::REG_COLS, 16);
    set_reg(gpfb_pkg::REG_ROWS, 4);
    set_reg(gpfb_pkg::REG_RECIP, $urandom_range(1, 24'hFFFFFF));
    set_reg(gpfb_pkg::REG_RATIO, $urandom_range(0, 65536));
    random_phase(135);

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

>>> files.f
rtl/gpfb_pkg.sv
rtl/gpfb_ram.sv
rtl/gpfb_front.sv
rtl/gpfb_back.sv
rtl/grid_to_particle_flip_blend.sv
dv/gpfb_checker.sv
dv/tb.sv
